[rtl/core/cdq_pkg.sv]
// Package for the circular deque: operation and status codes, fixed field widths
// and default sizes.
// It depends on nothing else. The RAM and the top level import it.
package cdq_pkg;

  // Port widths of the transfer fields.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned COUNT_W = 5;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned DEFAULT_DEPTH      = 16;
  localparam int unsigned DEFAULT_DATA_WIDTH = 64;

  // Operation codes. The two codes above peek rear do nothing.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_REAR  = 3'd5
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[rtl/core/cdq_ram.sv]
// Slot store of the circular deque: a single-port-write, single-port-read RAM.
// The read data is registered, so it arrives in the cycle after the read enable.
// It depends on cdq_pkg for its default sizes.
module cdq_ram #(
  parameter int unsigned DEPTH      = cdq_pkg::DEFAULT_DEPTH,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH,
  parameter int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);
  import cdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/circular_deque.sv]
// Circular deque: double-ended queue of DEPTH words held in one synchronous RAM.
// The result of a request appears in the cycle after its transfer, as the RAM read
// port is registered; one request per cycle unless a stalled result holds it off.
// Each request touches at most one slot, and a slot written by a push is visible
// to a read in the very next request, so no forwarding is needed.
// Reset (synchronous, active high) empties the deque and clears both pointers.
module circular_deque #(
  parameter int unsigned DEPTH      = cdq_pkg::DEFAULT_DEPTH,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            req_valid,
  output logic                            req_stall,
  input  cdq_pkg::func_t                  func,
  input  logic [cdq_pkg::WORD_W-1:0]      data_in,
  // Result channel.
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [cdq_pkg::WORD_W-1:0]      data_out,
  output cdq_pkg::status_t                status,
  output logic [cdq_pkg::COUNT_W-1:0]     entry_count,
  output logic                            is_empty,
  output logic                            is_full
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [AW-1:0] front_index, front_index_next;
  logic [AW-1:0] rear_index, rear_index_next;
  logic [CW-1:0] occupancy, occupancy_next;

  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  status_t       status_next;

  status_t       status_q;
  logic [CW-1:0] count_q;
  logic          read_ok_q;

  logic          occ_empty, occ_full;
  logic [AW-1:0] front_dec, rear_inc;

  // A new request is held off only while an unread result is stalled.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Pointer steps with wrap at either end of the store.
  assign front_dec = (front_index == '0) ? LAST_SLOT : front_index - AW'(1);
  assign rear_inc  = (rear_index == LAST_SLOT) ? '0 : rear_index + AW'(1);
  assign occ_empty = (occupancy == '0);
  assign occ_full  = (occupancy == FULL_COUNT);

  // Decode the request into a RAM access and the next pointer state.
  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    occupancy_next   = occupancy;
    wr_en            = 1'b0;
    wr_addr          = '0;
    rd_en            = 1'b0;
    rd_addr          = front_index;
    status_next      = ST_OK;
    unique case (func)
      FN_PUSH_FRONT, FN_PUSH_REAR: begin
        if (occ_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en          = 1'b1;
          occupancy_next = occupancy + CW'(1);
          if (occ_empty) begin
            // The first entry always lands in slot zero.
            front_index_next = '0;
            rear_index_next  = '0;
            wr_addr          = '0;
          end else if (func == FN_PUSH_FRONT) begin
            front_index_next = front_dec;
            wr_addr          = front_dec;
          end else begin
            rear_index_next = rear_inc;
            wr_addr         = rear_inc;
          end
        end
      end
      FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR: begin
        if (occ_empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = (func == FN_POP_FRONT || func == FN_PEEK_FRONT) ? front_index
                                                                     : rear_index;
          if (func == FN_POP_FRONT || func == FN_POP_REAR) begin
            occupancy_next = occupancy - CW'(1);
            if (occupancy == CW'(1)) begin
              // Emptying the deque returns both pointers to slot zero.
              front_index_next = '0;
              rear_index_next  = '0;
            end else if (func == FN_POP_FRONT) begin
              front_index_next = (front_index == LAST_SLOT) ? '0
                                                             : front_index + AW'(1);
            end else begin
              rear_index_next = (rear_index == '0) ? LAST_SLOT : rear_index - AW'(1);
            end
          end
        end
      end
      default: begin
        // Unused codes leave everything as it is.
      end
    endcase
  end

  // Slot store.
  cdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (wr_addr),
    .wr_data (DATA_WIDTH'(data_in)),
    .rd_en   (accept && rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      occupancy   <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      occupancy   <= occupancy_next;
    end
  end

  // Result valid: set by a transfer in, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload, which pairs with the RAM read data of the same request.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q  <= status_next;
      count_q   <= occupancy_next;
      read_ok_q <= rd_en;
    end
  end

  // Output fields.
  assign data_out    = read_ok_q ? WORD_W'(rd_data) : '0;
  assign status      = status_q;
  assign entry_count = COUNT_W'(count_q);
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == FULL_COUNT);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the circular deque: a clocked driver, a clocked monitor and a
// bit-accurate deque model that predicts every result.
// It depends on cdq_pkg and circular_deque only.
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  localparam int unsigned DEPTH       = DEFAULT_DEPTH;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int          RANDOM_OPS  = 1650;
  localparam int          STUCK_LIMIT = 4000;
  localparam int          SETTLE_CYC  = 20;
  localparam int          IDLE_PCT    = 32;
  localparam int          CALM_FROM   = 700;
  localparam int          CALM_TO     = 1000;

  // The two spare operation codes, which leave the deque untouched.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} mix_t;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [WORD_W-1:0] word;
    bit                drain;  // hold this operation back until every result is in
  } deque_op_t;

  typedef struct {
    logic [WORD_W-1:0]  word;
    status_t            st;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } deque_result_t;

  logic               clk;
  logic               rst;
  logic               req_valid = 1'b0;
  logic               req_stall;
  func_t              func = FN_PUSH_FRONT;
  logic [WORD_W-1:0]  data_in = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [WORD_W-1:0]  data_out;
  status_t            status;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;
  logic               is_full;

  deque_op_t     op_backlog[$];
  deque_result_t pending_results[$];
  int            fail_cnt = 0;
  int            sent_cnt = 0;
  int            done_cnt = 0;
  int            stuck_cycles = 0;

  // Model state of the deque.
  logic [WORD_W-1:0]  slot_mem[DEPTH];
  logic [IDX_W-1:0]   head_idx = '0;
  logic [IDX_W-1:0]   tail_idx = '0;
  logic [COUNT_W-1:0] fill = '0;

  circular_deque u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .data_in     (data_in),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .data_out    (data_out),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Applies one operation to the model and returns the result it should produce.
  // With a power-of-two depth the indices wrap naturally at their width.
  function automatic deque_result_t deque_apply(logic [FUNC_W-1:0] op,
                                                logic [WORD_W-1:0] word);
    deque_result_t r;
    r.word = '0;
    r.st   = ST_OK;
    case (op)
      FN_PUSH_FRONT, FN_PUSH_REAR: begin
        if (fill == DEPTH) begin
          r.st = ST_FULL;
        end else begin
          if (fill == 0) begin
            head_idx    = '0;
            tail_idx    = '0;
            slot_mem[0] = word;
          end else if (op == FN_PUSH_FRONT) begin
            head_idx           = head_idx - 1'b1;
            slot_mem[head_idx] = word;
          end else begin
            tail_idx           = tail_idx + 1'b1;
            slot_mem[tail_idx] = word;
          end
          fill = fill + 1'b1;
        end
      end
      FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR: begin
        if (fill == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.word = (op == FN_POP_FRONT || op == FN_PEEK_FRONT) ? slot_mem[head_idx]
                                                               : slot_mem[tail_idx];
          if (op == FN_POP_FRONT || op == FN_POP_REAR) begin
            fill = fill - 1'b1;
            if (fill == 0) begin
              head_idx = '0;
              tail_idx = '0;
            end else if (op == FN_POP_FRONT) begin
              head_idx = head_idx + 1'b1;
            end else begin
              tail_idx = tail_idx - 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.count = fill;
    r.empty = (fill == 0);
    r.full  = (fill == DEPTH);
    return r;
  endfunction

  // A data word biased towards the extremes and single set bits.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_read();
    case ($urandom_range(3))
      0: return FN_POP_FRONT;
      1: return FN_POP_REAR;
      2: return FN_PEEK_FRONT;
      default: return FN_PEEK_REAR;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_push();
    return $urandom_range(1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
  endfunction

  // Picks an operation according to the character of the current burst.
  function automatic logic [FUNC_W-1:0] pick_op(mix_t mix);
    int roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  return (roll < 75) ? pick_push() : pick_read();
      MIX_DRAIN: return (roll < 25) ? pick_push() : pick_read();
      MIX_EVEN:  return (roll < 50) ? pick_push() : pick_read();
      default:   return FUNC_W'($urandom_range(7));
    endcase
  endfunction

  task automatic queue_op(logic [FUNC_W-1:0] op, logic [WORD_W-1:0] word, bit drain);
    deque_op_t item;
    item.op    = op;
    item.word  = word;
    item.drain = drain;
    op_backlog.push_back(item);
  endtask

  task automatic flag_error(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int   made;
    int   burst;
    mix_t mix;
    rst = 1'b1;

    // Directed: reads on an empty deque, the spare codes, a fill that wraps the front pointer,
    // a refused push and reads at both ends of a full deque.
    queue_op(FN_POP_FRONT, '1, 1'b0);
    queue_op(FN_POP_REAR, '0, 1'b0);
    queue_op(FN_PEEK_FRONT, '1, 1'b0);
    queue_op(FN_PEEK_REAR, '0, 1'b0);
    queue_op(FN_SPARE_6, '1, 1'b0);
    queue_op(FN_SPARE_7, '1, 1'b0);
    for (int i = 0; i < DEPTH; i++) begin
      queue_op((i % 2 == 0) ? FN_PUSH_FRONT : FN_PUSH_REAR,
               (i == 0) ? '0 : (i == 1) ? '1 : {$urandom, $urandom}, 1'b0);
    end
    queue_op(FN_PUSH_REAR, '1, 1'b0);
    queue_op(FN_PEEK_FRONT, '0, 1'b0);
    queue_op(FN_PEEK_REAR, '0, 1'b0);
    queue_op(FN_POP_FRONT, '0, 1'b0);
    queue_op(FN_POP_REAR, '0, 1'b1);

    // Random: bursts that fill, drain or churn the deque, with some noise.
    made = 0;
    while (made < RANDOM_OPS) begin
      case ($urandom_range(9))
        0, 1, 2: mix = MIX_FILL;
        3, 4, 5: mix = MIX_DRAIN;
        6, 7, 8: mix = MIX_EVEN;
        default: mix = MIX_NOISE;
      endcase
      burst = $urandom_range(40, 20);
      for (int i = 0; i < burst && made < RANDOM_OPS; i++) begin
        queue_op(pick_op(mix), pick_word(), $urandom_range(199) == 0);
        made++;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sampled mid-cycle, once the driver and monitor have settled for the edge.
    while (op_backlog.size() > 0 || req_valid || pending_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Request driver: presents queued operations, idling at random outside a calm window.
  // A stalled transfer keeps its payload.
  always @(posedge clk) begin
    deque_op_t nxt;
    bit        held;
    bit        calm;
    bit        can_go;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      held = req_valid && req_stall;
      calm = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);
      if (!held) begin
        can_go = op_backlog.size() > 0;
        if (can_go && op_backlog[0].drain) begin
          can_go = !req_valid && pending_results.size() == 0;
        end
        if (can_go && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = op_backlog.pop_front();
          req_valid <= 1'b1;
          func      <= func_t'(nxt.op);
          data_in   <= nxt.word;
          sent_cnt++;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result transfer against the oldest prediction, then
  // predicts for any request transfer on the same edge, and stalls at random.
  always @(posedge clk) begin
    deque_result_t want;
    bit            calm;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          flag_error("result with no request outstanding", '0, data_out);
        end else begin
          want = pending_results.pop_front();
          if (data_out !== want.word) flag_error("data_out", want.word, data_out);
          if (status !== want.st) begin
            flag_error("status", WORD_W'(want.st), WORD_W'(status));
          end
          if (entry_count !== want.count) begin
            flag_error("entry_count", WORD_W'(want.count), WORD_W'(entry_count));
          end
          if (is_empty !== want.empty) begin
            flag_error("is_empty", WORD_W'(want.empty), WORD_W'(is_empty));
          end
          if (is_full !== want.full) begin
            flag_error("is_full", WORD_W'(want.full), WORD_W'(is_full));
          end
        end
        done_cnt++;
      end
      if (req_valid && !req_stall) begin
        pending_results.push_back(deque_apply(func, data_in));
      end
      calm = (done_cnt >= CALM_FROM) && (done_cnt < CALM_TO);
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

[circular_deque.f]
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/circular_deque.sv
tb/tb_top.sv
